[hdl/itda_pkg.sv]
package itda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int BCD_W      = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_REG_W  = NUM_DIGITS * BCD_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'h30;
    localparam logic [CHAR_W-1:0] MINUS_CODE   = 8'h2D;
    localparam logic [CHAR_W-1:0] DIGIT_NINE   = 8'h39;
    localparam logic [BCD_W-1:0]  DABBLE_LIMIT = 4'd5;
    localparam logic [BCD_W-1:0]  DABBLE_ADD   = 4'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic dabble;
        logic skip_digit;
        logic emit_sign;
        logic emit_digit;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic top_zero;
        logic negative;
    } t_status;

endpackage

[hdl/itda_dp.sv]
module itda_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [itda_pkg::VALUE_W-1:0]      i_value,
    input  itda_pkg::t_cmd                    i_cmd,
    output itda_pkg::t_status                 o_status,
    output logic [itda_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last_char,
    output logic                              o_char_valid
);

    logic [itda_pkg::VALUE_W-1:0]   r_mag,  n_mag;
    logic [itda_pkg::BCD_REG_W-1:0] r_bcd,  n_bcd;
    logic                           r_neg,  n_neg;
    logic [itda_pkg::CHAR_W-1:0]    r_char, n_char;
    logic                           r_last, n_last;
    logic                           r_valid;
    logic [itda_pkg::BCD_REG_W-1:0] adj_bcd;
    logic [itda_pkg::BCD_W-1:0]     top_digit;

    assign top_digit = r_bcd[itda_pkg::BCD_REG_W-1 -: itda_pkg::BCD_W];

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[d*itda_pkg::BCD_W +: itda_pkg::BCD_W] >= itda_pkg::DABBLE_LIMIT) begin
                adj_bcd[d*itda_pkg::BCD_W +: itda_pkg::BCD_W] =
                    r_bcd[d*itda_pkg::BCD_W +: itda_pkg::BCD_W] + itda_pkg::DABBLE_ADD;
            end else begin
                adj_bcd[d*itda_pkg::BCD_W +: itda_pkg::BCD_W] =
                    r_bcd[d*itda_pkg::BCD_W +: itda_pkg::BCD_W];
            end
        end
    end

    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_neg  = r_neg;
        n_char = r_char;
        n_last = r_last;
        if (i_cmd.load) begin
            n_neg = i_value[itda_pkg::VALUE_W-1];
            n_mag = n_neg ? (~i_value + 1'b1) : i_value;
            n_bcd = '0;
        end else if (i_cmd.dabble) begin
            n_bcd = {adj_bcd[itda_pkg::BCD_REG_W-2:0], r_mag[itda_pkg::VALUE_W-1]};
            n_mag = {r_mag[itda_pkg::VALUE_W-2:0], 1'b0};
        end else if (i_cmd.skip_digit || i_cmd.emit_digit) begin
            n_bcd = {r_bcd[itda_pkg::BCD_REG_W-itda_pkg::BCD_W-1:0], {itda_pkg::BCD_W{1'b0}}};
        end
        if (i_cmd.emit_sign) begin
            n_char = itda_pkg::MINUS_CODE;
            n_last = 1'b0;
        end else if (i_cmd.emit_digit) begin
            n_char = itda_pkg::DIGIT_BASE
                   + {{(itda_pkg::CHAR_W-itda_pkg::BCD_W){1'b0}}, top_digit};
            n_last = i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sign | i_cmd.emit_digit;
        end
    end

    assign o_status.top_zero = (top_digit == '0);
    assign o_status.negative = r_neg;
    assign o_char_code       = r_char;
    assign o_last_char       = r_last;
    assign o_char_valid      = r_valid;

endmodule

[hdl/itda_ctrl.sv]
module itda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  itda_pkg::t_status i_status,
    output itda_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    localparam logic [itda_pkg::BIT_CNT_W-1:0] LAST_BIT =
        itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_W - 1);
    localparam logic [itda_pkg::DIG_CNT_W-1:0] ALL_DIGITS =
        itda_pkg::DIG_CNT_W'(itda_pkg::NUM_DIGITS);
    localparam logic [itda_pkg::DIG_CNT_W-1:0] ONE_DIGIT =
        itda_pkg::DIG_CNT_W'(1);

    t_state                          r_state, n_state;
    logic [itda_pkg::BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [itda_pkg::DIG_CNT_W-1:0]  r_dig_cnt, n_dig_cnt;
    logic                            r_busy, n_busy;
    logic                            accept;

    assign accept = start && !r_busy;

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt  = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                n_bit_cnt    = r_bit_cnt + 1'b1;
                if (r_bit_cnt == LAST_BIT) begin
                    n_dig_cnt = ALL_DIGITS;
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_status.top_zero && (r_dig_cnt != ONE_DIGIT)) begin
                    o_cmd.skip_digit = 1'b1;
                    n_dig_cnt        = r_dig_cnt - 1'b1;
                end else begin
                    n_state = i_status.negative ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                o_cmd.last       = (r_dig_cnt == ONE_DIGIT);
                n_dig_cnt        = r_dig_cnt - 1'b1;
                if (r_dig_cnt == ONE_DIGIT) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

[hdl/int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text.
//
// Input channel: drive i_value and raise start. The word is taken at the
// rising edge where start is high and busy is low; busy then stays high
// until the last character of that number has been produced.
// Output channel: each character appears on o_char_code for exactly one
// cycle with o_char_valid high. Characters come most significant first,
// with a leading '-' for negative values, and o_last_char marks the final
// one. The receiver cannot stall, so it must take every strobed word.
// Sequence: after acceptance the magnitude goes through bit-serial
// double-dabble, one input bit per cycle. The ten BCD digits then leave
// the shifter one per cycle: leading zeros are dropped, the sign is picked,
// a '-' is emitted for a negative number, and the rest of the digits follow.
// The last character is strobed in the cycle that busy falls, so the next
// number may be accepted right then; no new number is taken while busy.
// Reset (synchronous, active low) returns the controller to idle and
// clears the strobe; a number in flight is dropped.
module int_to_decimal_ascii (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [itda_pkg::VALUE_W-1:0] i_value,
    output logic [itda_pkg::CHAR_W-1:0]        o_char_code,
    output logic                               o_last_char,
    output logic                               o_char_valid
);

    itda_pkg::t_cmd    cmd;
    itda_pkg::t_status status;

    // The controller sequences conversion, zero suppression and output.
    itda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds the magnitude, the BCD digits and the output word.
    itda_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char),
        .o_char_valid (o_char_valid)
    );

endmodule

[hdl/itda_checker.sv]
module itda_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [itda_pkg::VALUE_W-1:0] i_value,
    input logic [itda_pkg::CHAR_W-1:0]        o_char_code,
    input logic                               o_last_char,
    input logic                               o_char_valid
);

    // An accepted word keeps the block busy through its conversion.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_char_valid))
        else $error("accepted word did not start a conversion");

    // More characters follow a word that is not the last one.
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && !o_last_char) |-> busy)
        else $error("block went idle before the last character");

    // Only a minus sign or a decimal digit is ever produced.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> ((o_char_code == itda_pkg::MINUS_CODE) ||
                          ((o_char_code >= itda_pkg::DIGIT_BASE) &&
                           (o_char_code <= itda_pkg::DIGIT_NINE))))
        else $error("character code out of range");

    // A sign is always followed by at least one digit.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && (o_char_code == itda_pkg::MINUS_CODE)) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    // A sign is directly followed by a digit in the next cycle.
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && (o_char_code == itda_pkg::MINUS_CODE)) |=>
        (o_char_valid && (o_char_code != itda_pkg::MINUS_CODE)))
        else $error("minus sign not followed by a digit");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

[verif/itda_text_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the integer-to-text converter. Every accepted
// word is turned into the characters it should produce, and each strobed
// character is compared with the oldest one still owed.
module itda_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_value,
    input  logic [7:0]  o_char_code,
    input  logic        o_last_char,
    input  logic        o_char_valid,
    output int          fail_count,
    output int          chars_owed
);

    localparam int unsigned DECIMAL_RADIX = 10;
    localparam int          MAX_DIGITS    = itda_pkg::NUM_DIGITS;

    typedef struct {
        logic [7:0]  code;
        logic        last;
        logic [31:0] source;
    } ascii_char_t;

    ascii_char_t owed_chars[$];
    ascii_char_t oldest;

    initial begin
        fail_count = 0;
        chars_owed = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Appends the decimal text of one word, sign first, to the owed list.
    function automatic void predict_text(input logic [31:0] word);
        logic        negative;
        logic [31:0] magnitude;
        logic [3:0]  digit_stack[MAX_DIGITS];
        int          n_digits;
        ascii_char_t ch;
        negative  = word[31];
        magnitude = negative ? (~word + 32'd1) : word;
        n_digits  = 0;
        do begin
            digit_stack[n_digits] = 4'(magnitude % DECIMAL_RADIX);
            magnitude             = magnitude / DECIMAL_RADIX;
            n_digits++;
        end while (magnitude != 0 && n_digits < MAX_DIGITS);
        ch.source = word;
        if (negative) begin
            ch.code = itda_pkg::MINUS_CODE;
            ch.last = 1'b0;
            owed_chars.push_back(ch);
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            ch.code = itda_pkg::DIGIT_BASE + 8'(digit_stack[k]);
            ch.last = (k == 0);
            owed_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_char_valid === 1'b1) begin
                if (owed_chars.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h with nothing owed", o_char_code));
                end else begin
                    oldest = owed_chars.pop_front();
                    if (o_char_code !== oldest.code)
                        report_mismatch($sformatf("value %0d: char 0x%02h, wanted 0x%02h",
                            $signed(oldest.source), o_char_code, oldest.code));
                    if (o_last_char !== oldest.last)
                        report_mismatch($sformatf("value %0d: last flag %b, wanted %b",
                            $signed(oldest.source), o_last_char, oldest.last));
                end
            end else if (o_char_valid !== 1'b0) begin
                report_mismatch("character strobe is unknown");
            end
            // A word's characters only come out after its conversion, so a word
            // accepted here never owes the character seen at this same edge.
            if (start === 1'b1 && busy === 1'b0)
                predict_text(i_value);
        end
        chars_owed = owed_chars.size();
    end

endmodule

[verif/tb_int_to_decimal_ascii.sv]
`timescale 1ns / 100ps

// Top of the converter bench. It owns the clock, the reset and the word
// stimulus; all prediction and comparison live in the checker instance,
// which reports back how many mismatches it saw and how many characters
// are still owed.
module tb_int_to_decimal_ascii;

    // Each word costs one conversion, the sender's idle gap of up to MAX_GAP
    // and perhaps a wait for a whole conversion; about 375 words stay far
    // below this ceiling.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_WORDS   = 350;
    localparam int MAX_GAP        = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_value;
    logic [7:0]  o_char_code;
    logic        o_last_char;
    logic        o_char_valid;

    int fail_count;
    int chars_owed;
    int cycle_count;

    // Back-to-back stretches keep start high with no gap at all.
    bit burst_mode;

    // Directed words: zero, single digits, several digit-count boundaries, both
    // ends of the signed range including the most negative value.
    int directed_values[] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -54321,
        123456789, -987654321, 999999999, -999999999, 1000000000,
        -1000000000, 1999999999, 2000000000, 2147483647, -2147483647,
        32'sh8000_0000
    };

    int unsigned powers_of_ten[10] = '{
        1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
        100000000, 1000000000
    };

    int_to_decimal_ascii uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char),
        .o_char_valid (o_char_valid)
    );

    itda_text_checker text_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char),
        .o_char_valid (o_char_valid),
        .fail_count   (fail_count),
        .chars_owed   (chars_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a word is never taken or characters stop coming.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d characters owed", cycle_count, chars_owed);
        $display("== FAIL ==");
        $finish;
    end

    // Picks a word from one of several shapes. Uniform 32-bit words mostly
    // have nine or ten digits, so a digit count is drawn as well to spread
    // text lengths evenly; powers of ten and their neighbors probe carries
    // in the digit conversion.
    function automatic logic [31:0] random_word();
        longint lo;
        longint hi;
        longint mag;
        int     n_digits;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                n_digits = $urandom_range(1, 10);
                lo  = (n_digits == 1) ? 0 : powers_of_ten[n_digits-1];
                hi  = (n_digits == 10) ? 64'd2147483648 : powers_of_ten[n_digits] - 1;
                mag = lo + (longint'($urandom) % (hi - lo + 1));
                // Only the negative side can reach a magnitude of 2^31.
                if (mag == 64'd2147483648 || $urandom_range(0, 1))
                    return 32'(-mag);
                return 32'(mag);
            end
            2: begin
                mag = longint'(powers_of_ten[$urandom_range(0, 9)]) + $urandom_range(0, 2) - 1;
                return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Offers one word and returns at the rising edge that accepts it. The
    // idle time is either counted from the previous acceptance, so start
    // comes back while the block is still busy, or from the moment busy
    // drops, so the block also sits idle between numbers. While start is
    // low the value lines carry junk that must be ignored.
    task automatic send_value(input logic [31:0] word);
        int unsigned gap;
        bit          wait_idle;
        gap       = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        wait_idle = !burst_mode && ($urandom_range(0, 1) == 1);
        @(negedge i_clk);
        if (gap != 0 || wait_idle) begin
            start   <= 1'b0;
            i_value <= $urandom;
            if (wait_idle) begin
                do @(negedge i_clk); while (busy !== 1'b0);
            end else begin
                @(negedge i_clk);
                gap--;
            end
            repeat (gap) @(negedge i_clk);
        end
        i_value <= word;
        start   <= 1'b1;
        // busy is read before this edge's register updates take effect.
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    initial begin : stimulus
        start      = 1'b0;
        i_value    = '0;
        i_rst_n    = 1'b0;
        burst_mode = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_values[k])
            send_value(directed_values[k]);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Switch between gapped and back-to-back traffic now and then.
            if ($urandom_range(0, 24) == 0)
                burst_mode = ~burst_mode;
            send_value(random_word());
        end

        @(negedge i_clk);
        start <= 1'b0;

        // The checker updates its owed count at the rising edge, so it is
        // read at the falling edge.
        while (chars_owed != 0) @(negedge i_clk);
        // Let anything stray come out before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
